@@ hdl/epr_pkg.sv @@
// Package for the Euler point rotation unit: fixed-point constants,
// CORDIC arctangent table and helper types. No dependencies.
package epr_pkg;

    localparam int AngleWidth = 16;
    localparam int QWidth     = 34;   // Q2.30 values with headroom
    localparam int QFrac      = 30;

    localparam logic signed [QWidth-1:0] Q30One      = 34'sh040000000;
    localparam logic signed [QWidth-1:0] CordicGain  = 34'sh026DD3B6A;
    localparam logic signed [QWidth-1:0] HalfPiQ30   = 34'sh06487ED51;
    localparam logic signed [QWidth-1:0] PiQ30       = 34'sh0C90FDAA2;

    typedef logic signed [QWidth-1:0] t_q30;

    // One CORDIC lane: the vector and residual angle for one half angle.
    typedef struct packed {
        t_q30 x;
        t_q30 y;
        t_q30 z;
        logic neg_cos;
    } t_lane;

    typedef t_lane t_lanes [3];

    function automatic t_q30 atan_q30(input int unsigned idx);
        t_q30 v;
        v = '0;
        unique case (idx & 31)
            0: v = 34'sh03243F6A8;  1: v = 34'sh01DAC6705;
            2: v = 34'sh00FADBAFC;  3: v = 34'sh007F56EA6;
            4: v = 34'sh003FEAB76;  5: v = 34'sh001FFD55B;
            6: v = 34'sh000FFFAAA;  7: v = 34'sh0007FFF55;
            8: v = 34'sh0003FFFEA;  9: v = 34'sh0001FFFFD;
            10: v = 34'sh0000FFFFF; 11: v = 34'sh00007FFFF;
            12: v = 34'sh00003FFFF; 13: v = 34'sh00001FFFF;
            14: v = 34'sh00000FFFF; 15: v = 34'sh000007FFF;
            16: v = 34'sh000003FFF; 17: v = 34'sh000001FFF;
            18: v = 34'sh000000FFF; 19: v = 34'sh0000007FF;
            20: v = 34'sh0000003FF; 21: v = 34'sh0000001FF;
            22: v = 34'sh0000000FF; 23: v = 34'sh00000007F;
            24: v = 34'sh00000003F; 25: v = 34'sh00000001F;
            26: v = 34'sh00000000F; 27: v = 34'sh000000008;
            28: v = 34'sh000000004; 29: v = 34'sh000000002;
            30: v = 34'sh000000001;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Q2.30 product with floor rounding.
    function automatic t_q30 mul30(input t_q30 a, input t_q30 b);
        logic signed [2*QWidth-1:0] p;
        p = a * b;
        return t_q30'(p >>> QFrac);
    endfunction

endpackage

@@ hdl/euler_point_rotation_unit.sv @@
// Euler ZYX point rotation unit, top level.
// Depends on epr_pkg, epr_cordic_cell and epr_rotate_back.
//
// Rotates one Q16.16 point per cycle, unless the output stalls, by roll,
// pitch and yaw (Q3.13 radians). A request enters a chain of TRIG_STAGES
// CORDIC cells, one iteration each, that hand cosine/sine of the three half
// angles forward each cycle that the pipe advances, then a seven-stage back
// end forms the quaternion, the rotation matrix and the product with the
// point. Throughput is one request per cycle while not stalled. The whole
// pipe advances as one: a stall on the output holds every stage, while a bubble at the output is filled freely.
module euler_point_rotation_unit #(
    parameter int COORD_WIDTH = 32,
    parameter int TRIG_STAGES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [15:0]            i_roll_angle,
    input  logic signed [15:0]            i_pitch_angle,
    input  logic signed [15:0]            i_yaw_angle,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  logic signed [COORD_WIDTH-1:0] i_point_z,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [COORD_WIDTH-1:0] o_rotated_x,
    output logic signed [COORD_WIDTH-1:0] o_rotated_y,
    output logic signed [COORD_WIDTH-1:0] o_rotated_z
);
    import epr_pkg::*;

    logic en;
    t_lane in_lane [3];
    t_lane lane [TRIG_STAGES+1][3];
    logic [TRIG_STAGES:0] vld;
    logic signed [COORD_WIDTH-1:0] r_pt [TRIG_STAGES][3];
    logic signed [COORD_WIDTH-1:0] pt_in [3];
    logic signed [COORD_WIDTH-1:0] rot [3];
    logic [AngleWidth-1:0] ang [3];

    // Advance when the output slot is empty or being taken.
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    assign ang[0] = i_roll_angle;
    assign ang[1] = i_pitch_angle;
    assign ang[2] = i_yaw_angle;

    // Fold half angles beyond +-pi/2 and seed the CORDIC vector.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            t_q30 h;
            h = t_q30'($signed(ang[k])) <<< 16;
            in_lane[k].x = CordicGain;
            in_lane[k].y = '0;
            in_lane[k].neg_cos = 1'b0;
            in_lane[k].z = h;
            if (h > HalfPiQ30) begin
                in_lane[k].z = PiQ30 - h;
                in_lane[k].neg_cos = 1'b1;
            end else if (h < -HalfPiQ30) begin
                in_lane[k].z = -PiQ30 - h;
                in_lane[k].neg_cos = 1'b1;
            end
        end
    end

    assign lane[0] = in_lane;
    assign vld[0]  = i_valid;

    for (genvar g = 0; g < TRIG_STAGES; g++) begin : g_cell
        epr_cordic_cell #(.STAGE(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (vld[g]),
            .i_lane  (lane[g]),
            .o_valid (vld[g+1]),
            .o_lane  (lane[g+1])
        );
    end

    // Carry the point alongside the CORDIC chain.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pt[0] <= '{i_point_x, i_point_y, i_point_z};
            for (int d = 1; d < TRIG_STAGES; d++) r_pt[d] <= r_pt[d-1];
        end
    end

    assign pt_in = r_pt[TRIG_STAGES-1];

    epr_rotate_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (vld[TRIG_STAGES]),
        .i_lane  (lane[TRIG_STAGES]),
        .i_point (pt_in),
        .o_valid (o_valid),
        .o_rot   (rot)
    );

    assign o_rotated_x = rot[0];
    assign o_rotated_y = rot[1];
    assign o_rotated_z = rot[2];

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_rotated_x))) else $error("hold");
    // Stall only ever comes from a blocked output.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall)) else $error("stall");
    // The chain stops as one.
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(vld[TRIG_STAGES:1])) else $error("freeze");
endmodule

@@ hdl/epr_cordic_cell.sv @@
// One CORDIC iteration cell for three angle lanes plus a valid bit.
// Depends on epr_pkg.
module epr_cordic_cell #(
    parameter int unsigned STAGE = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  epr_pkg::t_lane i_lane [3],
    output logic           o_valid,
    output epr_pkg::t_lane o_lane [3]
);
    import epr_pkg::*;

    t_lane n_lane [3];
    t_lane r_lane [3];
    logic  r_valid;
    t_q30  atan_c;

    assign atan_c = atan_q30(STAGE);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_lane[k] = i_lane[k];
            if (!i_lane[k].z[QWidth-1]) begin
                n_lane[k].x = i_lane[k].x - (i_lane[k].y >>> STAGE);
                n_lane[k].y = i_lane[k].y + (i_lane[k].x >>> STAGE);
                n_lane[k].z = i_lane[k].z - atan_c;
            end else begin
                n_lane[k].x = i_lane[k].x + (i_lane[k].y >>> STAGE);
                n_lane[k].y = i_lane[k].y - (i_lane[k].x >>> STAGE);
                n_lane[k].z = i_lane[k].z + atan_c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;
endmodule

@@ hdl/epr_rotate_back.sv @@
// Back end: quaternion, rotation matrix and matrix-vector product, pipelined.
// Depends on epr_pkg.
module epr_rotate_back #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  epr_pkg::t_lane                i_lane [3],
    input  logic signed [COORD_WIDTH-1:0] i_point [3],
    output logic                          o_valid,
    output logic signed [COORD_WIDTH-1:0] o_rot [3]
);
    import epr_pkg::*;

    localparam int Depth   = 7;
    localparam int PtDepth = 5;   // the point waits for the matrix
    localparam int AccW    = COORD_WIDTH + 40;

    localparam logic signed [AccW-1:0] OutMax =
        $signed({{(AccW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}});
    localparam logic signed [AccW-1:0] OutMin = -OutMax - 1;

    logic [Depth-1:0] r_vld;
    logic signed [COORD_WIDTH-1:0] r_pt [PtDepth][3];

    // stage 0: cos/sin
    t_q30 r_c [3], r_s [3];
    // stage 1: pairwise products
    t_q30 r_cc, r_ss, r_sc, r_cs, r_c2, r_s2;
    // stage 2: quaternion
    t_q30 r_qw, r_qx, r_qy, r_qz;
    // stage 3: quaternion products
    t_q30 r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    // stage 4: matrix
    t_q30 r_m [3][3];
    // stage 5: partial sums
    logic signed [AccW-1:0] r_hi [3], r_lo [3];
    // stage 6: saturated output
    logic signed [COORD_WIDTH-1:0] r_out [3];

    function automatic t_q30 clamp1(input t_q30 v);
        if (v > Q30One) return Q30One;
        if (v < -Q30One) return -Q30One;
        return v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[Depth-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pt[0] <= i_point;
            for (int d = 1; d < PtDepth; d++) r_pt[d] <= r_pt[d-1];
            for (int k = 0; k < 3; k++) begin
                r_c[k] <= i_lane[k].neg_cos ? -i_lane[k].x : i_lane[k].x;
                r_s[k] <= i_lane[k].y;
            end
            // cr*cp, sr*sp, sr*cp, cr*sp, cy, sy carried
            r_cc <= mul30(r_c[0], r_c[1]);
            r_ss <= mul30(r_s[0], r_s[1]);
            r_sc <= mul30(r_s[0], r_c[1]);
            r_cs <= mul30(r_c[0], r_s[1]);
            r_c2 <= r_c[2];
            r_s2 <= r_s[2];
            r_qw <= mul30(r_cc, r_c2) + mul30(r_ss, r_s2);
            r_qx <= mul30(r_sc, r_c2) - mul30(r_cs, r_s2);
            r_qy <= mul30(r_cs, r_c2) + mul30(r_sc, r_s2);
            r_qz <= mul30(r_cc, r_s2) - mul30(r_ss, r_c2);
            r_xx <= mul30(r_qx, r_qx); r_yy <= mul30(r_qy, r_qy);
            r_zz <= mul30(r_qz, r_qz); r_xy <= mul30(r_qx, r_qy);
            r_xz <= mul30(r_qx, r_qz); r_yz <= mul30(r_qy, r_qz);
            r_wx <= mul30(r_qw, r_qx); r_wy <= mul30(r_qw, r_qy);
            r_wz <= mul30(r_qw, r_qz);
            r_m[0][0] <= clamp1(Q30One - ((r_yy + r_zz) <<< 1));
            r_m[0][1] <= clamp1((r_xy - r_wz) <<< 1);
            r_m[0][2] <= clamp1((r_xz + r_wy) <<< 1);
            r_m[1][0] <= clamp1((r_xy + r_wz) <<< 1);
            r_m[1][1] <= clamp1(Q30One - ((r_xx + r_zz) <<< 1));
            r_m[1][2] <= clamp1((r_yz - r_wx) <<< 1);
            r_m[2][0] <= clamp1((r_xz - r_wy) <<< 1);
            r_m[2][1] <= clamp1((r_yz + r_wx) <<< 1);
            r_m[2][2] <= clamp1(Q30One - ((r_xx + r_yy) <<< 1));
            for (int i = 0; i < 3; i++) begin
                logic signed [AccW-1:0] hi, lo, tot;
                hi = '0;
                lo = '0;
                for (int j = 0; j < 3; j++) begin
                    hi += AccW'(r_m[i][j]) * AccW'(r_pt[PtDepth-1][j] >>> 16);
                    lo += AccW'(r_m[i][j]) * AccW'({1'b0, r_pt[PtDepth-1][j][15:0]});
                end
                r_hi[i] <= hi;
                r_lo[i] <= lo;
                tot = (r_hi[i] + (r_lo[i] >>> 16)) >>> 14;
                if (tot > OutMax)
                    r_out[i] <= {1'b0, {(COORD_WIDTH-1){1'b1}}};
                else if (tot < OutMin)
                    r_out[i] <= {1'b1, {(COORD_WIDTH-1){1'b0}}};
                else
                    r_out[i] <= COORD_WIDTH'(tot);
            end
        end
    end

    assign o_valid = r_vld[Depth-1];
    assign o_rot   = r_out;
endmodule

@@ tb/sv/tb_euler_point_rotation_unit.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for euler_point_rotation_unit: directed and random
// Euler angle / point requests checked against a bit-exact rotation predictor.
// Depends on the RTL top level, and through it on epr_pkg.
module tb_euler_point_rotation_unit;

    localparam int CoordW     = 32;
    localparam int TrigStages = 16;
    localparam int PipeDepth  = TrigStages + 7;
    localparam int StuckLimit = 5000;

    typedef struct {
        logic signed [15:0]       roll;
        logic signed [15:0]       pitch;
        logic signed [15:0]       yaw;
        logic signed [CoordW-1:0] px;
        logic signed [CoordW-1:0] py;
        logic signed [CoordW-1:0] pz;
    } t_request;

    typedef struct {
        logic signed [CoordW-1:0] rx;
        logic signed [CoordW-1:0] ry;
        logic signed [CoordW-1:0] rz;
    } t_rotated;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic signed [15:0]       i_roll_angle;
    logic signed [15:0]       i_pitch_angle;
    logic signed [15:0]       i_yaw_angle;
    logic signed [CoordW-1:0] i_point_x;
    logic signed [CoordW-1:0] i_point_y;
    logic signed [CoordW-1:0] i_point_z;
    logic                     o_valid;
    logic                     i_stall;
    logic signed [CoordW-1:0] o_rotated_x;
    logic signed [CoordW-1:0] o_rotated_y;
    logic signed [CoordW-1:0] o_rotated_z;

    t_rotated expected_points[$];
    int       error_count;
    int       sender_idle_pct;
    int       stall_pct;
    int       stuck_cycles;

    euler_point_rotation_unit #(
        .COORD_WIDTH(CoordW),
        .TRIG_STAGES(TrigStages)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_roll_angle (i_roll_angle),
        .i_pitch_angle(i_pitch_angle),
        .i_yaw_angle  (i_yaw_angle),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_point_z    (i_point_z),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_rotated_x  (o_rotated_x),
        .o_rotated_y  (o_rotated_y),
        .o_rotated_z  (o_rotated_z)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------
    // Predictor: CORDIC sin/cos of half angles, quaternion, matrix,
    // matrix times point with floor rounding and saturation.
    // ---------------------------------------------------------------
    longint arctan_q30[32] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
        64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
        64'h00000001, 64'h00000000
    };

    function automatic longint fx_mul(input longint a, input longint b);
        return (a * b) >>> 30;
    endfunction

    function automatic longint limit_to(input longint v, input longint lo,
                                        input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Half angle in Q2.30; fold beyond +-pi/2 and flip the cosine there.
    function automatic void half_angle_trig(input longint h, output longint c,
                                            output longint s);
        longint x, y, z, dx, dy;
        bit     flip_cos;
        flip_cos = 1'b0;
        if (h > 64'sh6487ED51) begin
            h = 64'shC90FDAA2 - h;
            flip_cos = 1'b1;
        end else if (h < -64'sh6487ED51) begin
            h = -64'shC90FDAA2 - h;
            flip_cos = 1'b1;
        end
        x = 64'sh26DD3B6A;
        y = 0;
        z = h;
        for (int i = 0; i < TrigStages; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= arctan_q30[i];
            end else begin
                x += dx; y -= dy; z += arctan_q30[i];
            end
        end
        c = flip_cos ? -x : x;
        s = y;
    endfunction

    function automatic t_rotated rotate_point(input t_request rq);
        longint cr, sr, cp, sp, cy, sy, qw, qx, qy, qz;
        longint xx, yy, zz, xy, xz, yz, wx, wy, wz, hi, lo, ph, acc;
        longint m[3][3];
        longint p[3];
        longint r[3];
        longint one;
        t_rotated res;
        one = 64'sd1 << 30;
        half_angle_trig(longint'(rq.roll) * 65536, cr, sr);
        half_angle_trig(longint'(rq.pitch) * 65536, cp, sp);
        half_angle_trig(longint'(rq.yaw) * 65536, cy, sy);
        p[0] = rq.px; p[1] = rq.py; p[2] = rq.pz;
        qw = fx_mul(fx_mul(cr, cp), cy) + fx_mul(fx_mul(sr, sp), sy);
        qx = fx_mul(fx_mul(sr, cp), cy) - fx_mul(fx_mul(cr, sp), sy);
        qy = fx_mul(fx_mul(cr, sp), cy) + fx_mul(fx_mul(sr, cp), sy);
        qz = fx_mul(fx_mul(cr, cp), sy) - fx_mul(fx_mul(sr, sp), cy);
        xx = fx_mul(qx, qx); yy = fx_mul(qy, qy); zz = fx_mul(qz, qz);
        xy = fx_mul(qx, qy); xz = fx_mul(qx, qz); yz = fx_mul(qy, qz);
        wx = fx_mul(qw, qx); wy = fx_mul(qw, qy); wz = fx_mul(qw, qz);
        m[0][0] = one - 2 * (yy + zz);
        m[0][1] = 2 * (xy - wz);
        m[0][2] = 2 * (xz + wy);
        m[1][0] = 2 * (xy + wz);
        m[1][1] = one - 2 * (xx + zz);
        m[1][2] = 2 * (yz - wx);
        m[2][0] = 2 * (xz - wy);
        m[2][1] = 2 * (yz + wx);
        m[2][2] = one - 2 * (xx + yy);
        for (int i = 0; i < 3; i++) begin
            hi = 0;
            lo = 0;
            for (int j = 0; j < 3; j++) begin
                // split the point so the products stay inside 64 bits
                acc = limit_to(m[i][j], -one, one);
                ph = p[j] >>> 16;
                hi += acc * ph;
                lo += acc * (p[j] - ph * 65536);
            end
            r[i] = limit_to((hi + (lo >>> 16)) >>> 14,
                            -(64'sd1 << (CoordW - 1)), (64'sd1 << (CoordW - 1)) - 1);
        end
        res.rx = r[0][CoordW-1:0];
        res.ry = r[1][CoordW-1:0];
        res.rz = r[2][CoordW-1:0];
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Request driver: drive at the rising edge, sample stall mid-cycle.
    // ---------------------------------------------------------------
    task automatic send_request(input t_request rq);
        logic held;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_roll_angle  <= rq.roll;
        i_pitch_angle <= rq.pitch;
        i_yaw_angle   <= rq.yaw;
        i_point_x     <= rq.px;
        i_point_y     <= rq.py;
        i_point_z     <= rq.pz;
        do begin
            @(negedge i_clk);
            held = o_stall;
            @(posedge i_clk);
        end while (held);
        expected_points.insert(expected_points.size(), rotate_point(rq));
    endtask

    task automatic go_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] any_angle();
        // mostly the stated range, sometimes any 16-bit pattern
        if ($urandom_range(9) == 0)
            return 16'($urandom);
        return 16'($signed($urandom_range(2 * 25736)) - 25736);
    endfunction

    function automatic logic signed [CoordW-1:0] any_coord();
        case ($urandom_range(3))
            0: return CoordW'($urandom);
            1: return CoordW'($signed($urandom_range(1 << 21)) - (1 << 20));
            2: return $urandom_range(1) ? {1'b0, {(CoordW-1){1'b1}}}
                                        : {1'b1, {(CoordW-1){1'b0}}};
            default: return CoordW'($signed($urandom_range(1 << 25)) - (1 << 24));
        endcase
    endfunction

    // Extremes of every field, folding angles and output saturation.
    task automatic test_directed();
        t_request rq;
        logic signed [15:0]       angs[8] = '{16'sd0, 16'sd25736, -16'sd25736,
                                              16'sd12868, -16'sd12868, 16'sh7FFF,
                                              16'sh8000, 16'sd1};
        logic signed [CoordW-1:0] pts[4] = '{32'sd0, 32'sh7FFFFFFF, 32'sh80000000,
                                             32'sh00010000};
        for (int k = 0; k < 8; k++) begin
            rq.roll  = angs[k];
            rq.pitch = angs[(k + 3) % 8];
            rq.yaw   = angs[(k + 5) % 8];
            rq.px    = pts[k % 4];
            rq.py    = pts[(k + 1) % 4];
            rq.pz    = pts[(k + 2) % 4];
            send_request(rq);
        end
        // all-ones patterns on every field, then saturating corners and alternating-bit patterns
        rq = '{16'shFFFF, 16'shFFFF, 16'shFFFF, -32'sd1, -32'sd1, -32'sd1};
        send_request(rq);
        rq = '{16'sd0, 16'sd0, 16'sd0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000};
        send_request(rq);
        rq = '{16'sd6434, 16'sd6434, 16'sd6434, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
               32'sh7FFFFFFF};
        send_request(rq);
        rq = '{-16'sd6434, 16'sd25736, -16'sd6434, 32'sh80000000, 32'sh80000000,
               32'sh80000000};
        send_request(rq);
        rq = '{16'sh5555, 16'shAAAA, 16'sh5555, 32'shAAAAAAAA, 32'sh55555555,
               32'shAAAAAAAA};
        send_request(rq);
        rq = '{16'shAAAA, 16'sh5555, 16'shAAAA, 32'sh55555555, 32'shAAAAAAAA,
               32'sh55555555};
        send_request(rq);
        go_idle();
    endtask

    task automatic test_random(input int count, input int idle_pct, input int hold_pct);
        t_request rq;
        sender_idle_pct = idle_pct;
        stall_pct       = hold_pct;
        for (int n = 0; n < count; n++) begin
            rq.roll  = any_angle();
            rq.pitch = any_angle();
            rq.yaw   = any_angle();
            rq.px    = any_coord();
            rq.py    = any_coord();
            rq.pz    = any_coord();
            send_request(rq);
        end
        go_idle();
    endtask

    // Drain: wait until every expected point has come back.
    task automatic wait_drained();
        while (expected_points.size() != 0)
            @(posedge i_clk);
    endtask

    // Receiver stall, redrawn every cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_stall <= 1'b0;
        else
            i_stall <= ($urandom_range(99) < stall_pct);
    end

    // Result checker: outputs and stall are stable at the falling edge.
    always @(negedge i_clk) begin
        t_rotated want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_points.size() == 0) begin
                $error("unexpected result x=%0d y=%0d z=%0d",
                       o_rotated_x, o_rotated_y, o_rotated_z);
                error_count++;
            end else begin
                want = expected_points.pop_front();
                if (o_rotated_x !== want.rx) begin
                    $error("rotated_x expected %0d actual %0d", want.rx, o_rotated_x);
                    error_count++;
                end
                if (o_rotated_y !== want.ry) begin
                    $error("rotated_y expected %0d actual %0d", want.ry, o_rotated_y);
                    error_count++;
                end
                if (o_rotated_z !== want.rz) begin
                    $error("rotated_z expected %0d actual %0d", want.rz, o_rotated_z);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(negedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= StuckLimit) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        error_count     = 0;
        sender_idle_pct = 0;
        stall_pct       = 0;
        stuck_cycles    = 0;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_stall         = 1'b0;
        i_roll_angle    = '0;
        i_pitch_angle   = '0;
        i_yaw_angle     = '0;
        i_point_x       = '0;
        i_point_y       = '0;
        i_point_z       = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(225, 0, 0);
        test_random(225, 67, 0);
        test_random(225, 0, 67);
        test_random(225, 25, 25);
        stall_pct = 0;

        wait_drained();
        repeat (PipeDepth + 16) @(posedge i_clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
